/* rtl/coverage_alpha_pixel_blend_unit_macros.svh */
// Assertion macros shared by the coverage alpha blend RTL.
`ifndef COVERAGE_ALPHA_PIXEL_BLEND_UNIT_MACROS_SVH
`define COVERAGE_ALPHA_PIXEL_BLEND_UNIT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CAB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define CAB_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

`endif

/* rtl/cab_pkg.sv */
// Shared constants and pipeline payload types of the coverage alpha blend unit.
package cab_pkg;

    localparam int unsigned ChanW     = 8;
    localparam int unsigned NumChan   = 3;
    localparam int unsigned SumW      = ChanW + 1;
    localparam int unsigned RemW      = 2 * ChanW + 1;
    localparam int unsigned ProdW     = 2 * ChanW;
    localparam int unsigned DivStages = 4;

    localparam logic [ChanW-1:0] FullScale     = 8'd255;
    localparam logic [ChanW-1:0] CoverageReset = 8'd255;
    localparam logic [ProdW-1:0] RoundBias     = 16'h0080;

    typedef logic [NumChan-1:0][ChanW-1:0] t_rgb;

    // One accepted pixel pair.
    typedef struct packed {
        t_rgb             back;
        t_rgb             fore;
        logic [ChanW-1:0] alpha;
    } t_pixel;

    // Colours, background weight and the biased coverage times alpha product.
    typedef struct packed {
        t_rgb             back;
        t_rgb             fore;
        logic [ChanW-1:0] wb;
        logic [ProdW-1:0] prod;
    } t_prod;

    // Colours with both layer weights.
    typedef struct packed {
        t_rgb             back;
        t_rgb             fore;
        logic [ChanW-1:0] wb;
        logic [ChanW-1:0] wf;
    } t_weight;

    // Per-channel divider state: partial remainder and quotient bits so far.
    typedef struct packed {
        logic [NumChan-1:0][RemW-1:0] rem;
        t_rgb                         quot;
        logic [SumW-1:0]              sum;
        logic                         zero;
    } t_div;

endpackage

/* rtl/cab_weight.sv */
// Two pipeline stages that form the background and foreground layer weights.
module cab_weight (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [cab_pkg::ChanW-1:0]       i_coverage,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  cab_pkg::t_pixel                 i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output cab_pkg::t_weight                o_data
);

    logic                    r_valid_a;
    logic                    r_valid_b;
    cab_pkg::t_prod          r_prod;
    cab_pkg::t_prod          n_prod;
    cab_pkg::t_weight        r_wgt;
    cab_pkg::t_weight        n_wgt;
    logic                    w_ready_a;
    logic                    w_ready_b;
    logic [cab_pkg::ProdW-1:0] w_fold;

    // A stage takes a new request when it is empty or its content moves on.
    assign w_ready_b = !r_valid_b || i_ready;
    assign w_ready_a = !r_valid_a || w_ready_b;
    assign o_ready   = w_ready_a;

    // First stage: coverage times alpha plus the rounding bias. The background
    // weight (255 - coverage) * 255 / 255 rounds back to 255 - coverage exactly.
    always_comb begin
        n_prod.back = i_data.back;
        n_prod.fore = i_data.fore;
        n_prod.wb   = cab_pkg::FullScale - i_coverage;
        n_prod.prod = i_coverage * i_data.alpha + cab_pkg::RoundBias;
    end

    // Second stage: divide by 255 with the shift-and-add fold.
    assign w_fold = {{cab_pkg::ChanW{1'b0}}, r_prod.prod[cab_pkg::ProdW-1:cab_pkg::ChanW]}
                    + r_prod.prod;

    always_comb begin
        n_wgt.back = r_prod.back;
        n_wgt.fore = r_prod.fore;
        n_wgt.wb   = r_prod.wb;
        n_wgt.wf   = w_fold[cab_pkg::ProdW-1:cab_pkg::ChanW];
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_valid_a <= i_valid;
            end
            if (w_ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_prod <= n_prod;
        end
        if (w_ready_b && r_valid_a) begin
            r_wgt <= n_wgt;
        end
    end

    assign o_valid = r_valid_b;
    assign o_data  = r_wgt;

endmodule

/* rtl/cab_mix.sv */
// Pipeline stage that forms the weighted colour sums and the weight total.
`include "coverage_alpha_pixel_blend_unit_macros.svh"

module cab_mix (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  cab_pkg::t_weight i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output cab_pkg::t_div    o_data
);

    logic                       r_valid;
    cab_pkg::t_div              r_data;
    cab_pkg::t_div              n_data;
    logic                       w_ready;
    logic [cab_pkg::RemW-1:0]   w_bound;

    assign w_ready = !r_valid || i_ready;
    assign o_ready = w_ready;

    // Numerator of each channel and the sum of the two weights. Each product
    // keeps its full 16 bits before the two are added.
    always_comb begin
        logic [cab_pkg::ProdW-1:0] v_back;
        logic [cab_pkg::ProdW-1:0] v_fore;
        n_data.sum  = {1'b0, i_data.wb} + {1'b0, i_data.wf};
        n_data.zero = (n_data.sum == '0);
        n_data.quot = '0;
        for (int c = 0; c < cab_pkg::NumChan; c++) begin
            v_back = {{cab_pkg::ChanW{1'b0}}, i_data.back[c]}
                   * {{cab_pkg::ChanW{1'b0}}, i_data.wb};
            v_fore = {{cab_pkg::ChanW{1'b0}}, i_data.fore[c]}
                   * {{cab_pkg::ChanW{1'b0}}, i_data.wf};
            n_data.rem[c] = {1'b0, v_back} + {1'b0, v_fore};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // A weighted mean never exceeds 255, so each numerator is at most 255 * sum.
    assign w_bound = {r_data.sum, {cab_pkg::ChanW{1'b0}}} - {{cab_pkg::ChanW{1'b0}}, r_data.sum};

    `CAB_ASSERT_IMPL(a_num_bound, i_clk, i_rst_n, r_valid,
        (r_data.rem[0] <= w_bound) && (r_data.rem[1] <= w_bound) && (r_data.rem[2] <= w_bound),
        "weighted colour sum exceeds 255 times the weight total")

endmodule

/* rtl/cab_div_step.sv */
// Divider pipeline stage that resolves two quotient bits of every channel.
`include "coverage_alpha_pixel_blend_unit_macros.svh"

module cab_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cab_pkg::t_div i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output cab_pkg::t_div o_data
);

    logic                     r_valid;
    cab_pkg::t_div            r_data;
    cab_pkg::t_div            n_data;
    logic                     w_ready;
    logic [cab_pkg::RemW-1:0] w_den;

    assign w_ready = !r_valid || i_ready;
    assign o_ready = w_ready;

    // The divisor sits aligned to the top quotient bit; the remainder shifts
    // left after each compare, so every step uses the same divisor.
    assign w_den = {1'b0, i_data.sum, 7'd0};

    // Two restoring steps on each channel.
    always_comb begin
        logic [cab_pkg::RemW-1:0]  v_rem;
        logic [cab_pkg::ChanW-1:0] v_quot;
        n_data = i_data;
        for (int c = 0; c < cab_pkg::NumChan; c++) begin
            v_rem  = i_data.rem[c];
            v_quot = i_data.quot[c];
            for (int k = 0; k < 2; k++) begin
                if (v_rem >= w_den) begin
                    v_rem  = v_rem - w_den;
                    v_quot = {v_quot[cab_pkg::ChanW-2:0], 1'b1};
                end else begin
                    v_quot = {v_quot[cab_pkg::ChanW-2:0], 1'b0};
                end
                v_rem = {v_rem[cab_pkg::RemW-2:0], 1'b0};
            end
            n_data.rem[c]  = v_rem;
            n_data.quot[c] = v_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    // After each step the shifted remainder stays below twice the aligned divisor.
    `CAB_ASSERT_IMPL(a_rem_bound, i_clk, i_rst_n, r_valid && !r_data.zero,
        (r_data.rem[0] < {r_data.sum, 8'd0}) && (r_data.rem[1] < {r_data.sum, 8'd0})
        && (r_data.rem[2] < {r_data.sum, 8'd0}),
        "divider remainder out of range")

endmodule

/* rtl/coverage_alpha_pixel_blend_unit.sv */
// Top level of the coverage alpha blend unit: RGBA foreground over RGB background.
//
// Usage:
//   Slave stream: one request per pixel pair, 56-bit tdata holding the background
//   red, green, blue, then the foreground red, green, blue and alpha bytes.
//   Master stream: one request per pixel, 24-bit tdata holding red, green, blue.
//   Configuration channel: an 8-bit coverage alpha, always ready; write it only
//   while no pixel is in flight. Reset sets the coverage to 255.
//   Seven register stages: two weight stages, one numerator stage and four divider
//   stages of two quotient bits, passed in that order; o_m_axis_tvalid is the
//   valid bit of the last divider stage.
//   Throughput is one pixel per clock while the receiver keeps tready high.
//   When the receiver stalls, requests stop in the stages they occupy and the
//   empty stages keep filling; tready drops only when all seven stages are full.
//   Reset clears every valid bit, so the pipeline comes up empty.
//   When both weights are zero (coverage 255, alpha 0) the pixel is black.
`include "coverage_alpha_pixel_blend_unit_macros.svh"

module coverage_alpha_pixel_blend_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: coverage alpha.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    // Pixel pairs in.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // back_red, back_green, back_blue, fore_red, fore_green, fore_blue, fore_alpha
    input  logic [55:0] i_s_axis_tdata,
    // Blended pixels out.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_red, out_green, out_blue
    output logic [23:0] o_m_axis_tdata
);

    logic [cab_pkg::ChanW-1:0]      r_coverage;
    cab_pkg::t_pixel                w_pixel;
    cab_pkg::t_weight               w_wgt;
    logic                           w_wgt_valid;
    logic                           w_wgt_ready;
    cab_pkg::t_div                  w_div [cab_pkg::DivStages+1];
    logic [cab_pkg::DivStages:0]    w_div_valid;
    logic [cab_pkg::DivStages:0]    w_div_ready;

    // Coverage register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coverage <= cab_pkg::CoverageReset;
        end else if (i_cfg_valid) begin
            r_coverage <= i_cfg_data;
        end
    end

    // Unpack the input request.
    always_comb begin
        for (int c = 0; c < cab_pkg::NumChan; c++) begin
            w_pixel.back[c] = i_s_axis_tdata[c*8 +: 8];
            w_pixel.fore[c] = i_s_axis_tdata[24 + c*8 +: 8];
        end
        w_pixel.alpha = i_s_axis_tdata[55:48];
    end

    // Layer weights.
    cab_weight u_weight (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_coverage (r_coverage),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_data     (w_pixel),
        .o_valid    (w_wgt_valid),
        .i_ready    (w_wgt_ready),
        .o_data     (w_wgt)
    );

    // Weighted sums.
    cab_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_wgt_valid),
        .o_ready (w_wgt_ready),
        .i_data  (w_wgt),
        .o_valid (w_div_valid[0]),
        .i_ready (w_div_ready[0]),
        .o_data  (w_div[0])
    );

    // Divider pipeline.
    for (genvar g = 0; g < cab_pkg::DivStages; g++) begin : g_div
        cab_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_div_valid[g]),
            .o_ready (w_div_ready[g]),
            .i_data  (w_div[g]),
            .o_valid (w_div_valid[g+1]),
            .i_ready (w_div_ready[g+1]),
            .o_data  (w_div[g+1])
        );
    end

    // Output: the last divider register; zero total weight gives black.
    assign w_div_ready[cab_pkg::DivStages] = i_m_axis_tready;
    assign o_m_axis_tvalid = w_div_valid[cab_pkg::DivStages];
    assign o_m_axis_tdata  = w_div[cab_pkg::DivStages].zero ? '0
                                                            : w_div[cab_pkg::DivStages].quot;

    // The input side only backs up when the whole pipeline is full and stalled.
    `CAB_ASSERT_ALWAYS(a_full_only_when_stalled, i_clk, i_rst_n,
        o_s_axis_tready || (o_m_axis_tvalid && !i_m_axis_tready),
        "input not ready although the output is moving")

    // Input back-pressure means every stage holds a request; the ready chain is combinational.
    `CAB_ASSERT_IMPL(a_ready_chain, i_clk, i_rst_n, !o_s_axis_tready,
        (&w_div_valid) && w_wgt_valid,
        "input held off while a pipeline stage is empty")

endmodule

/* tb/sv/coverage_alpha_pixel_blend_unit_test.sv */
// Self-checking testbench of the coverage alpha blend unit, with its own blend predictor.
module coverage_alpha_pixel_blend_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // One pixel pair as it travels on the slave tdata, back_red in the lowest byte.
    typedef struct packed {
        logic [7:0] fore_alpha;
        logic [7:0] fore_blue;
        logic [7:0] fore_green;
        logic [7:0] fore_red;
        logic [7:0] back_blue;
        logic [7:0] back_green;
        logic [7:0] back_red;
    } t_pixel_pair;

    // One blended pixel as it travels on the master tdata, red in the lowest byte.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_blended_rgb;

    localparam int unsigned MaxReports    = 10;
    localparam int unsigned SettleCycles  = 12;
    localparam realtime     RunLimit      = 4_000_000ns;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // back_red, back_green, back_blue, fore_red, fore_green, fore_blue, fore_alpha
    logic [55:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // out_red, out_green, out_blue
    logic [23:0] o_m_axis_tdata;

    // Predictor state and bookkeeping.
    logic [7:0]   blend_coverage;
    t_blended_rgb expected_pixels[$];
    int unsigned  send_idle_pct;
    int unsigned  recv_idle_pct;
    int unsigned  pairs_sent;
    int unsigned  pixels_checked;
    int unsigned  zero_weight_pairs;
    int unsigned  coverage_writes;
    int unsigned  mismatch_count;
    int unsigned  unexpected_count;
    int unsigned  leftover_count;
    int unsigned  report_count;

    coverage_alpha_pixel_blend_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Free-running clock, 20 ns period.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Product of two 8-bit values divided by 255, rounded by the add-and-shift trick.
    function automatic logic [7:0] scale_div255(logic [7:0] x, logic [7:0] y);
        int unsigned t;
        t = int'(x) * int'(y) + int'(cab_pkg::RoundBias);
        return 8'(((t >> 8) + t) >> 8);
    endfunction

    // Weighted mean of one background and one foreground channel, truncated.
    function automatic logic [7:0] mix_channel(logic [7:0] back, logic [7:0] fore,
                                               logic [7:0] wb, logic [7:0] wf);
        int unsigned num;
        num = int'(back) * int'(wb) + int'(fore) * int'(wf);
        return 8'(num / (int'(wb) + int'(wf)));
    endfunction

    // Expected blend of one pixel pair under the current coverage.
    function automatic t_blended_rgb blend_pixel(t_pixel_pair p);
        logic [7:0]   wb;
        logic [7:0]   wf;
        t_blended_rgb px;
        wb = scale_div255(cab_pkg::FullScale - blend_coverage, cab_pkg::FullScale);
        wf = scale_div255(blend_coverage, p.fore_alpha);
        if (wb == 0 && wf == 0) begin
            px = '0;
        end else begin
            px.red   = mix_channel(p.back_red,   p.fore_red,   wb, wf);
            px.green = mix_channel(p.back_green, p.fore_green, wb, wf);
            px.blue  = mix_channel(p.back_blue,  p.fore_blue,  wb, wf);
        end
        return px;
    endfunction

    function automatic t_pixel_pair make_pair(logic [7:0] br, logic [7:0] bg, logic [7:0] bb,
                                              logic [7:0] fr, logic [7:0] fg, logic [7:0] fb,
                                              logic [7:0] fa);
        t_pixel_pair p;
        p.back_red   = br;
        p.back_green = bg;
        p.back_blue  = bb;
        p.fore_red   = fr;
        p.fore_green = fg;
        p.fore_blue  = fb;
        p.fore_alpha = fa;
        return p;
    endfunction

    // Random pair; alpha leans towards fully transparent and fully opaque now and then.
    function automatic t_pixel_pair random_pair();
        t_pixel_pair p;
        int unsigned pick;
        p    = 56'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 12) begin
            p.fore_alpha = 8'd0;
        end else if (pick < 24) begin
            p.fore_alpha = 8'd255;
        end
        return p;
    endfunction

    // Random coverage, with both extremes coming up often.
    function automatic logic [7:0] random_coverage();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15) begin
            return 8'd0;
        end else if (pick < 30) begin
            return 8'd255;
        end
        return 8'($urandom);
    endfunction

    // Receiver side: stalls at random at the rate of the current phase.
    initial begin
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each delivered pixel with the oldest expectation.
    always @(posedge i_clk) begin
        t_blended_rgb got;
        t_blended_rgb want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (expected_pixels.size() == 0) begin
                unexpected_count++;
                if (report_count < MaxReports) begin
                    $display("unexpected pixel r/g/b %02h/%02h/%02h with nothing pending",
                             got.red, got.green, got.blue);
                end
                report_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue) begin
                    mismatch_count++;
                    if (report_count < MaxReports) begin
                        $display("pixel %0d: expected r/g/b %02h/%02h/%02h, got %02h/%02h/%02h",
                                 pixels_checked, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                    end
                    report_count++;
                end
                pixels_checked++;
            end
        end
    end

    // Offer one pair, idling first at the sender's rate, and hold it until accepted.
    task automatic send_pair(t_pixel_pair p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= p;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        expected_pixels.push_back(blend_pixel(p));
        if (blend_coverage == cab_pkg::FullScale && p.fore_alpha == 0) begin
            zero_weight_pairs++;
        end
        pairs_sent++;
    endtask

    // Stop offering pairs until every pending pixel has come back.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_pixels.size() != 0);
    endtask

    // Change the coverage once the pipeline is empty.
    task automatic write_coverage(logic [7:0] value);
        wait_drained();
        repeat (SettleCycles) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        blend_coverage  = value;
        coverage_writes++;
        @(posedge i_clk);
    endtask

    // Random pairs in chunks, each chunk under a fresh coverage.
    task automatic run_random_blends(int unsigned count, int unsigned s_pct, int unsigned r_pct);
        int unsigned left;
        int unsigned chunk;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        left = count;
        while (left > 0) begin
            write_coverage(random_coverage());
            chunk = $urandom_range(70, 30);
            if (chunk > left) begin
                chunk = left;
            end
            repeat (chunk) send_pair(random_pair());
            left -= chunk;
        end
    endtask

    task automatic reset_block();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n        <= 1'b1;
        blend_coverage  = cab_pkg::CoverageReset;
        @(posedge i_clk);
    endtask

    // Coverage left at its reset value: opaque, transparent and both weights zero.
    task automatic test_reset_coverage();
        send_pair(make_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pair(make_pair(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00));
        send_pair(make_pair(8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff));
        send_pair(make_pair(8'hff, 8'h00, 8'haa, 8'h00, 8'hff, 8'h55, 8'h01));
        send_pair(make_pair(8'haa, 8'haa, 8'haa, 8'h55, 8'h55, 8'h55, 8'h80));
        send_pair(make_pair(8'h12, 8'h34, 8'h56, 8'hfe, 8'hdc, 8'hba, 8'hfe));
    endtask

    // Extreme and middle coverage settings against extreme and middle alphas.
    task automatic test_coverage_extremes();
        // No coverage: the background passes through untouched.
        write_coverage(8'd0);
        send_pair(make_pair(8'hff, 8'h00, 8'haa, 8'h00, 8'hff, 8'h55, 8'hff));
        send_pair(make_pair(8'h01, 8'h80, 8'hfe, 8'hff, 8'hff, 8'hff, 8'h00));
        write_coverage(8'd1);
        send_pair(make_pair(8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff));
        send_pair(make_pair(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h80));
        write_coverage(8'd254);
        send_pair(make_pair(8'h00, 8'hff, 8'h55, 8'hff, 8'h00, 8'haa, 8'hff));
        send_pair(make_pair(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h01));
        send_pair(make_pair(8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h00));
        write_coverage(8'd128);
        send_pair(make_pair(8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff));
        send_pair(make_pair(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pair(make_pair(8'h7f, 8'h80, 8'h81, 8'h81, 8'h80, 8'h7f, 8'h80));
        // Full coverage again: zero weights after a change, then fully opaque.
        write_coverage(8'd255);
        send_pair(make_pair(8'hff, 8'h55, 8'haa, 8'h01, 8'h02, 8'h03, 8'h00));
        send_pair(make_pair(8'hff, 8'h55, 8'haa, 8'h01, 8'h02, 8'h03, 8'hff));
    endtask

    task automatic test_busy_sender_slow_receiver();
        run_random_blends(270, 33, 86);
    endtask

    task automatic test_slow_sender_busy_receiver();
        run_random_blends(270, 86, 33);
    endtask

    // Back-to-back traffic, with one full drain in the middle of a burst.
    task automatic test_full_rate();
        run_random_blends(130, 0, 0);
        repeat (40) send_pair(random_pair());
        wait_drained();
        repeat (90) send_pair(random_pair());
    endtask

    task automatic finish_run();
        wait_drained();
        repeat (SettleCycles * 2) @(posedge i_clk);
        leftover_count = expected_pixels.size();
        $display("Blended %0d pixel pairs under %0d coverage writes, %0d with both weights zero.",
                 pairs_sent, coverage_writes, zero_weight_pairs);
        $display("Checked %0d pixels: %0d mismatches, %0d unexpected, %0d missing.",
                 pixels_checked, mismatch_count, unexpected_count, leftover_count);
        if (mismatch_count == 0 && unexpected_count == 0 && leftover_count == 0) begin
            $display("coverage_alpha_pixel_blend_unit_test OK");
        end else begin
            $display("coverage_alpha_pixel_blend_unit_test NOT OK");
        end
        $finish;
    endtask

    // Test sequence; every input driven here is known from the first instant.
    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_valid       <= 1'b0;
        i_cfg_data        <= '0;
        i_s_axis_tvalid   <= 1'b0;
        i_s_axis_tdata    <= '0;
        pairs_sent        = 0;
        pixels_checked    = 0;
        zero_weight_pairs = 0;
        coverage_writes   = 0;
        mismatch_count    = 0;
        unexpected_count  = 0;
        leftover_count    = 0;
        report_count      = 0;
        blend_coverage    = cab_pkg::CoverageReset;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        reset_block();
        test_reset_coverage();
        test_coverage_extremes();
        test_busy_sender_slow_receiver();
        test_slow_sender_busy_receiver();
        test_full_rate();
        finish_run();
    end

    // Watchdog against a hung handshake.
    initial begin
        #RunLimit;
        $display("Run stopped by timeout with %0d pixels pending.", expected_pixels.size());
        $display("coverage_alpha_pixel_blend_unit_test NOT OK");
        $finish;
    end

endmodule

/* coverage_alpha_pixel_blend_unit.f */
+incdir+rtl
rtl/cab_pkg.sv
rtl/cab_weight.sv
rtl/cab_mix.sv
rtl/cab_div_step.sv
rtl/coverage_alpha_pixel_blend_unit.sv
tb/sv/coverage_alpha_pixel_blend_unit_test.sv
